FILE: design/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

  // Default geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 4;

  // Cell layout: attribute in the high byte, character in the low byte
  localparam int          CELL_W     = 16;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  // Control characters
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;

  // Configuration register reset values
  localparam logic [7:0] TEXT_COLOR_RST = 8'h0F;
  localparam logic [6:0] BS_FLOOR_RST   = 7'd8;

  // Configuration register index (word select of the APB address)
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_BS_FLOOR   = 1'b1;

  // Request actions
  typedef enum logic [2:0] {
    ACT_PRINT     = 3'd0,
    ACT_BACKSPACE = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_SET_POS   = 3'd3,
    ACT_READ_CELL = 3'd4
  } tcw_action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_SWEEP,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } tcw_state_t;

endpackage

FILE: design/tcw_screen_ram.sv
// Screen cell memory: one write port, one read port, registered read data.
module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tcw_pkg::CELL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [tcw_pkg::CELL_W-1:0] rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/text_console_writer_core.sv
// Text console writer: top level with sequencer, cursor state and config port.
//
// A ROWS x COLUMNS text screen held in one memory, with a logical cursor and
// a displayed cursor location. A request is taken when start is high and busy
// is low; its single result appears on the out_ ports for one cycle with
// out_valid high and must be taken then, since the receiver cannot stall.
// Each request passes the states CALC (memory address and displayed location)
// and DONE before IDLE again. Tab, plain newline, set position, a backspace
// that does not act, a read cell out of range and unused actions go straight
// from CALC to DONE; printing a character and a backspace that acts pass
// WRITE, a read cell in range passes READ (the memory access). Scrolling does
// not move rows: a rotating top-row pointer maps logical rows onto memory
// rows, so a scroll only blanks one row in SWEEP, one cell per cycle, before
// DONE, or before WRITE for a print that wraps and scrolls. Clear screen
// blanks every cell through the single write port in SWEEP. After reset the
// block clears the memory in INIT with busy high; configuration writes are
// taken throughout.
module text_console_writer_core #(
  parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_character,
  input  logic [6:0]  in_target_column,
  input  logic [4:0]  in_target_row,
  // result channel
  output logic        out_valid,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_displayed_cursor,
  output logic [7:0]  out_cell_character,
  output logic [7:0]  out_cell_color,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);
  localparam int DW     = AW + 1;
  localparam int CW     = $clog2(COLUMNS + 1);
  localparam int CIW    = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);

  // ---------------------------------------------------------------------------
  // Registers
  tcw_pkg::tcw_state_t state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [RW-1:0]  top_r, top_nxt;
  logic [10:0]    disp_r, disp_nxt;
  logic [7:0]     color_r, color_nxt;
  logic [6:0]     floor_r, floor_nxt;
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;
  logic           sweep_row_r, sweep_row_nxt;
  logic           sweep_all_r, sweep_all_nxt;
  logic           show_r, show_nxt;
  logic [AW-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]  sweep_end_r, sweep_end_nxt;
  // payload
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [CIW-1:0]           acol_r, acol_nxt;
  logic [RW-1:0]            arow_r, arow_nxt;
  logic [tcw_pkg::CELL_W-1:0] wdata_r, wdata_nxt;

  // Memory port
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  // ---------------------------------------------------------------------------
  // Cursor arithmetic helpers
  logic [CW:0]   tab_sum;
  logic          col_at_edge;
  logic          row_last;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] top_inc;
  logic          bs_ok;
  logic [CW-1:0] set_col;
  logic [RW-1:0] set_row;
  logic          rd_in_range;

  assign tab_sum     = (CW+1)'(col_r) + (CW+1)'(TAB_WIDTH);
  assign col_at_edge = (col_r >= CW'(COLUMNS));
  assign row_last    = (row_r == RW'(ROWS - 1));
  assign row_inc     = row_r + RW'(1);
  assign top_inc     = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
  assign bs_ok       = (32'(col_r) > 32'(floor_r));
  assign set_col     = (32'(in_target_column) > 32'(COLUMNS)) ? CW'(COLUMNS)
                                                               : CW'(in_target_column);
  assign set_row     = (32'(in_target_row) > 32'(ROWS - 1)) ? RW'(ROWS - 1)
                                                             : RW'(in_target_row);
  assign rd_in_range = (32'(in_target_column) < 32'(COLUMNS)) &&
                       (32'(in_target_row) < 32'(ROWS));

  // Logical row to memory row through the rotating top pointer
  logic [RW:0]   phys_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] row_base;
  logic [AW-1:0] cell_addr;
  logic [DW-1:0] disp_full;

  assign phys_sum  = {1'b0, arow_r} + {1'b0, top_r};
  assign phys_row  = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                                  : RW'(phys_sum);
  assign row_base  = AW'(phys_row) * AW'(COLUMNS);
  assign cell_addr = row_base + AW'(acol_r);
  assign disp_full = DW'(row_r) * DW'(COLUMNS) + DW'(col_r);

  // ---------------------------------------------------------------------------
  // Sequencer: next state and memory control
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    top_nxt        = top_r;
    disp_nxt       = disp_r;
    wr_nxt         = wr_r;
    rd_nxt         = rd_r;
    sweep_row_nxt  = sweep_row_r;
    sweep_all_nxt  = sweep_all_r;
    show_nxt       = show_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_end_nxt  = sweep_end_r;
    addr_nxt       = addr_r;
    acol_nxt       = acol_r;
    arow_nxt       = arow_r;
    wdata_nxt      = wdata_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = wdata_r;
    ram_re         = 1'b0;

    case (state_r)
      // blank every cell after reset
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_r;
        ram_wdata = tcw_pkg::BLANK_CELL;
        if (sweep_addr_r == sweep_end_r) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + AW'(1);
        end
      end

      // take a request, update the cursor, note the memory work
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt     = tcw_pkg::ST_CALC;
          wr_nxt        = 1'b0;
          rd_nxt        = 1'b0;
          sweep_row_nxt = 1'b0;
          sweep_all_nxt = 1'b0;
          show_nxt      = 1'b0;
          arow_nxt      = row_r;
          acol_nxt      = CIW'(col_r);
          wdata_nxt     = tcw_pkg::BLANK_CELL;
          case (tcw_pkg::tcw_action_t'(in_action))
            tcw_pkg::ACT_PRINT: begin
              if (in_character == tcw_pkg::CHAR_NEWLINE) begin
                col_nxt = '0;
                if (!row_last) begin
                  row_nxt = row_inc;
                end else begin
                  top_nxt       = top_inc;
                  sweep_row_nxt = 1'b1;
                  show_nxt      = 1'b1;
                end
              end else if (in_character == tcw_pkg::CHAR_TAB) begin
                col_nxt = (tab_sum > (CW+1)'(COLUMNS)) ? CW'(COLUMNS) : CW'(tab_sum);
              end else begin
                // wrap first when the column sits at the edge
                wr_nxt    = 1'b1;
                show_nxt  = 1'b1;
                wdata_nxt = {color_r, in_character};
                if (col_at_edge) begin
                  acol_nxt = '0;
                  col_nxt  = CW'(1);
                  if (!row_last) begin
                    row_nxt  = row_inc;
                    arow_nxt = row_inc;
                  end else begin
                    top_nxt       = top_inc;
                    sweep_row_nxt = 1'b1;
                  end
                end else begin
                  col_nxt = col_r + CW'(1);
                end
              end
            end
            tcw_pkg::ACT_BACKSPACE: begin
              if (bs_ok) begin
                col_nxt  = col_r - CW'(1);
                acol_nxt = CIW'(col_r - CW'(1));
                wr_nxt   = 1'b1;
                show_nxt = 1'b1;
              end
            end
            tcw_pkg::ACT_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              top_nxt       = '0;
              sweep_all_nxt = 1'b1;
              show_nxt      = 1'b1;
            end
            tcw_pkg::ACT_SET_POS: begin
              col_nxt = set_col;
              row_nxt = set_row;
            end
            tcw_pkg::ACT_READ_CELL: begin
              rd_nxt   = rd_in_range;
              arow_nxt = RW'(in_target_row);
              acol_nxt = CIW'(in_target_column);
            end
            default: begin
            end
          endcase
        end
      end

      // form memory address and displayed location
      tcw_pkg::ST_CALC: begin
        addr_nxt = cell_addr;
        if (show_r) begin
          disp_nxt = 11'(disp_full);
        end
        if (sweep_all_r) begin
          sweep_addr_nxt = '0;
          sweep_end_nxt  = AW'(NCELLS - 1);
          state_nxt      = tcw_pkg::ST_SWEEP;
        end else if (sweep_row_r) begin
          sweep_addr_nxt = row_base;
          sweep_end_nxt  = row_base + AW'(COLUMNS - 1);
          state_nxt      = tcw_pkg::ST_SWEEP;
        end else if (wr_r) begin
          state_nxt = tcw_pkg::ST_WRITE;
        end else if (rd_r) begin
          state_nxt = tcw_pkg::ST_READ;
        end else begin
          state_nxt = tcw_pkg::ST_DONE;
        end
      end

      // blank a row or the whole screen
      tcw_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_r;
        ram_wdata = tcw_pkg::BLANK_CELL;
        if (sweep_addr_r == sweep_end_r) begin
          state_nxt = wr_r ? tcw_pkg::ST_WRITE : tcw_pkg::ST_DONE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + AW'(1);
        end
      end

      tcw_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_DONE: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    color_nxt = color_r;
    floor_nxt = floor_r;
    if (cfg_wr) begin
      case (paddr[2])
        tcw_pkg::REG_TEXT_COLOR: color_nxt = pwdata[7:0];
        tcw_pkg::REG_BS_FLOOR:   floor_nxt = pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tcw_pkg::REG_TEXT_COLOR: prdata = 32'(color_r);
      tcw_pkg::REG_BS_FLOOR:   prdata = 32'(floor_r);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::ST_INIT;
      col_r        <= '0;
      row_r        <= '0;
      top_r        <= '0;
      disp_r       <= '0;
      color_r      <= tcw_pkg::TEXT_COLOR_RST;
      floor_r      <= tcw_pkg::BS_FLOOR_RST;
      wr_r         <= 1'b0;
      rd_r         <= 1'b0;
      sweep_row_r  <= 1'b0;
      sweep_all_r  <= 1'b0;
      show_r       <= 1'b0;
      sweep_addr_r <= '0;
      sweep_end_r  <= AW'(NCELLS - 1);
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      top_r        <= top_nxt;
      disp_r       <= disp_nxt;
      color_r      <= color_nxt;
      floor_r      <= floor_nxt;
      wr_r         <= wr_nxt;
      rd_r         <= rd_nxt;
      sweep_row_r  <= sweep_row_nxt;
      sweep_all_r  <= sweep_all_nxt;
      show_r       <= show_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_end_r  <= sweep_end_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    acol_r  <= acol_nxt;
    arow_r  <= arow_nxt;
    wdata_r <= wdata_nxt;
  end

  // ---------------------------------------------------------------------------
  // Screen memory
  tcw_screen_ram #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshake and result
  assign busy                 = (state_r != tcw_pkg::ST_IDLE);
  assign out_valid            = (state_r == tcw_pkg::ST_DONE);
  assign out_cursor_column    = 7'(col_r);
  assign out_cursor_row       = 5'(row_r);
  assign out_displayed_cursor = disp_r;
  assign out_cell_character   = rd_r ? ram_rdata[7:0]  : 8'd0;
  assign out_cell_color       = rd_r ? ram_rdata[15:8] : 8'd0;

  // ---------------------------------------------------------------------------
  // Assertions
  a_valid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a busy request");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted request did not start the sequencer");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (32'(top_r) < 32'(ROWS)) &&
    (32'(col_r) <= 32'(COLUMNS)))
    else $error("cursor or top row out of range");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_SWEEP) |-> (sweep_addr_r <= sweep_end_r))
    else $error("blanking pass ran past its end");

endmodule

FILE: tb/sv/text_console_writer_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console writer core: directed and random requests.
module text_console_writer_core_test;
  import tcw_pkg::*;

  localparam int COLUMNS    = DEF_COLUMNS;
  localparam int ROWS       = DEF_ROWS;
  localparam int TAB_WIDTH  = DEF_TAB_WIDTH;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Action codes the block does not decode
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  // Register byte addresses
  localparam logic [2:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
  localparam logic [2:0] ADDR_BS_FLOOR   = {REG_BS_FLOOR, 2'b00};

  // A clear walks 2000 cells; allow that several times over
  localparam int STALL_LIMIT   = 10000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int PHASE_ITEMS   = 250;

  typedef struct packed {
    logic [6:0]  column;
    logic [4:0]  row;
    logic [10:0] shown;
    logic [7:0]  chr;
    logic [7:0]  attr;
  } console_view_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [7:0]  in_character;
  logic [6:0]  in_target_column;
  logic [4:0]  in_target_row;
  logic        out_valid;
  logic [6:0]  out_cursor_column;
  logic [4:0]  out_cursor_row;
  logic [10:0] out_displayed_cursor;
  logic [7:0]  out_cell_character;
  logic [7:0]  out_cell_color;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer_core dut (.*);

  // Predicted console state
  logic [15:0]   screen_model [CELL_COUNT];
  int unsigned   model_col;
  int unsigned   model_row;
  logic [10:0]   model_shown;
  logic [7:0]    model_color;
  logic [6:0]    model_floor;

  console_view_t expected_views [$];
  int            mismatch_count;
  int            sender_idle_pct;
  int            stall_cycles;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void model_store(int unsigned c, int unsigned r, logic [15:0] v);
    if (c < COLUMNS && r < ROWS) screen_model[r * COLUMNS + c] = v;
  endfunction

  function automatic void model_show();
    model_shown = 11'(model_row * COLUMNS + model_col);
  endfunction

  // Next row, or scroll up and blank the bottom row
  function automatic void model_line_feed();
    model_col = 0;
    if (model_row < ROWS - 1) begin
      model_row++;
    end else begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) model_store(c, ROWS - 1, BLANK_CELL);
      model_show();
    end
  endfunction

  // Apply one request to the predicted state and return the expected result
  function automatic console_view_t console_step(logic [2:0] act, logic [7:0] ch,
                                                 logic [6:0] tcol, logic [4:0] trow);
    console_view_t v;
    v = '0;
    case (act)
      ACT_PRINT: begin
        if (ch == CHAR_NEWLINE) begin
          model_line_feed();
        end else if (ch == CHAR_TAB) begin
          model_col += TAB_WIDTH;
          if (model_col > COLUMNS) model_col = COLUMNS;
        end else begin
          // cursor parked past the edge wraps first
          if (model_col >= COLUMNS) model_line_feed();
          model_store(model_col, model_row, {model_color, ch});
          model_col++;
          model_show();
        end
      end
      ACT_BACKSPACE: begin
        if (model_col > model_floor) begin
          model_col--;
          model_store(model_col, model_row, BLANK_CELL);
          model_show();
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
        model_col = 0;
        model_row = 0;
        model_show();
      end
      ACT_SET_POS: begin
        model_col = (tcol > COLUMNS) ? COLUMNS : 32'(tcol);
        model_row = (trow > ROWS - 1) ? ROWS - 1 : 32'(trow);
      end
      ACT_READ_CELL: begin
        if (tcol < COLUMNS && trow < ROWS) {v.attr, v.chr} = screen_model[trow * COLUMNS + tcol];
      end
      default: ;
    endcase
    v.column = model_col[6:0];
    v.row    = model_row[4:0];
    v.shown  = model_shown;
    return v;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Send one request; random idle cycles before it
  task automatic send_request(logic [2:0] act, logic [7:0] ch, logic [6:0] tcol,
                              logic [4:0] trow);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_action        <= act;
    in_character     <= ch;
    in_target_column <= tcol;
    in_target_row    <= trow;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_views.push_back(console_step(act, ch, tcol, trow));
  endtask

  // Drop start and wait until every result is in and the block is idle
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_transfer(logic is_write, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers while idle, then read them back
  task automatic set_registers(logic [7:0] color, logic [6:0] floor_value);
    logic [31:0] readback;
    wait_drained();
    apb_transfer(1'b1, ADDR_TEXT_COLOR, {24'd0, color}, readback);
    apb_transfer(1'b1, ADDR_BS_FLOOR, {25'd0, floor_value}, readback);
    model_color = color;
    model_floor = floor_value;
    apb_transfer(1'b0, ADDR_TEXT_COLOR, '0, readback);
    check_field("text_color readback", {24'd0, color}, readback);
    apb_transfer(1'b0, ADDR_BS_FLOOR, '0, readback);
    check_field("backspace_floor readback", {25'd0, floor_value}, readback);
  endtask

  // Random request, mostly text and cursor moves with reads to observe the screen
  task automatic random_request();
    int unsigned pick;
    logic [2:0]  act;
    logic [7:0]  ch;
    logic [6:0]  tcol;
    logic [4:0]  trow;
    pick = $urandom_range(99);
    act  = ACT_PRINT;
    ch   = 8'($urandom_range(255));
    tcol = 7'($urandom_range(127));
    trow = 5'($urandom_range(31));
    if (pick < 53) begin
      // plain text, newline, tab, else any byte
      if (pick < 38) ch = 8'($urandom_range(126, 32));
      else if (pick < 44) ch = CHAR_NEWLINE;
      else if (pick < 49) ch = CHAR_TAB;
    end else if (pick < 64) begin
      act = ACT_BACKSPACE;
    end else if (pick < 75) begin
      act = ACT_SET_POS;
      if ($urandom_range(4) != 0) begin
        tcol = 7'($urandom_range(COLUMNS));
        trow = 5'($urandom_range(ROWS - 1));
      end
    end else if (pick < 97) begin
      act = ACT_READ_CELL;
      // bias reads toward the cursor row, where text was just written
      if ($urandom_range(1) == 0) begin
        trow = (model_row < ROWS) ? model_row[4:0] : 5'(ROWS - 1);
        tcol = 7'($urandom_range(COLUMNS - 1));
      end else if ($urandom_range(3) != 0) begin
        trow = 5'($urandom_range(ROWS - 1));
        tcol = 7'($urandom_range(COLUMNS - 1));
      end
    end else if (pick < 98) begin
      act = ACT_CLEAR;
    end else begin
      act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
    end
    send_request(act, ch, tcol, trow);
  endtask

  // Extreme bytes, tab saturation, wrap and plain newline
  task automatic test_print_and_wrap();
    send_request(ACT_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_request(ACT_PRINT, 8'h00, 7'd127, 5'd31);
    send_request(ACT_PRINT, 8'hFF, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'hFF, 7'd1, 5'd0);
    send_request(ACT_SET_POS, 8'h00, 7'd78, 5'd0);
    send_request(ACT_PRINT, CHAR_TAB, 7'd0, 5'd0);
    send_request(ACT_PRINT, 8'h41, 7'd0, 5'd0);
    send_request(ACT_PRINT, CHAR_NEWLINE, 7'd0, 5'd0);
  endtask

  // Print that wraps into a scroll, then a newline that scrolls
  task automatic test_scroll();
    send_request(ACT_SET_POS, 8'h00, 7'd79, 5'd24);
    send_request(ACT_PRINT, 8'h5A, 7'd0, 5'd0);
    send_request(ACT_PRINT, 8'h59, 7'd0, 5'd0);
    send_request(ACT_PRINT, CHAR_NEWLINE, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'h00, 7'd79, 5'd22);
  endtask

  // Saturated set position, reads off screen, an unused action
  task automatic test_position_limits();
    send_request(ACT_SET_POS, 8'h00, 7'd127, 5'd31);
    send_request(ACT_READ_CELL, 8'h00, 7'd80, 5'd0);
    send_request(ACT_READ_CELL, 8'h00, 7'd0, 5'd25);
    send_request(ACT_UNUSED_FIRST, 8'hA5, 7'd5, 5'd5);
  endtask

  // Backspace against the floor; color changes; clear
  task automatic test_backspace_color_clear();
    set_registers(8'hFF, 7'd0);
    send_request(ACT_SET_POS, 8'h00, 7'd1, 5'd3);
    send_request(ACT_PRINT, 8'h71, 7'd0, 5'd0);
    send_request(ACT_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_request(ACT_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_request(ACT_BACKSPACE, 8'h00, 7'd0, 5'd0);
    set_registers(8'h00, 7'd80);
    send_request(ACT_PRINT, 8'h6B, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'h00, 7'd0, 5'd3);
    send_request(ACT_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(ACT_READ_CELL, 8'h00, 7'd0, 5'd3);
  endtask

  task automatic test_random_traffic(int idle_pct, logic [7:0] color, logic [6:0] floor_value);
    set_registers(color, floor_value);
    sender_idle_pct = idle_pct;
    repeat (PHASE_ITEMS) random_request();
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    console_view_t want;
    if (rst_n && out_valid) begin
      if (expected_views.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual column %0d row %0d",
                 $time, out_cursor_column, out_cursor_row);
      end else begin
        want = expected_views.pop_front();
        check_field("cursor_column", 32'(want.column), 32'(out_cursor_column));
        check_field("cursor_row", 32'(want.row), 32'(out_cursor_row));
        check_field("displayed_cursor", 32'(want.shown), 32'(out_displayed_cursor));
        check_field("cell_character", 32'(want.chr), 32'(out_cell_character));
        check_field("cell_color", 32'(want.attr), 32'(out_cell_color));
      end
    end
  end

  // Watchdog: too long with no request or result taken
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_action        = '0;
    in_character     = '0;
    in_target_column = '0;
    in_target_row    = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mismatch_count   = 0;
    stall_cycles     = 0;
    sender_idle_pct  = 7;
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
    model_col   = 0;
    model_row   = 0;
    model_shown = '0;
    model_color = TEXT_COLOR_RST;
    model_floor = BS_FLOOR_RST;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_print_and_wrap();
    test_scroll();
    test_position_limits();
    test_backspace_color_clear();

    test_random_traffic(7, TEXT_COLOR_RST, BS_FLOOR_RST);
    test_random_traffic(7, 8'h00, 7'd0);
    test_random_traffic(59, 8'hFF, 7'd80);
    test_random_traffic(59, 8'($urandom_range(255)), 7'($urandom_range(COLUMNS)));
    test_random_traffic(0, 8'($urandom_range(255)), 7'd79);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tcw_pkg.sv
design/tcw_screen_ram.sv
design/text_console_writer_core.sv
tb/sv/text_console_writer_core_test.sv
